@@ rtl/core/max_heap_insert_and_sort_unit_defines.svh @@
// Assertion macros used by the heap unit's datapath RTL.
`ifndef MAX_HEAP_INSERT_AND_SORT_UNIT_DEFINES_SVH
`define MAX_HEAP_INSERT_AND_SORT_UNIT_DEFINES_SVH

// Property that must hold in the same cycle.
`define MHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after the antecedent.
`define MHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mhs_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the heap unit.
package mhs_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_DISPLAY = 2'd1;
  localparam logic [1:0] ACT_SORT    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS_RD,
    OP_INS_MOVE,
    OP_INS_PLACE,
    OP_EMIT_INS,
    OP_EMIT_FULL,
    OP_EMIT_EMPTY,
    OP_SRT_RD,
    OP_SRT_SWAP,
    OP_SD_RD,
    OP_SD_MOVE,
    OP_SD_PLACE,
    OP_RD_I,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   clear_count;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic leaf;
    logic sort_done;
    logic up_move;
    logic dn_move;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/core/mhs_datapath.sv @@
// Heap datapath: element store, pointers, comparators and output register.
`include "max_heap_insert_and_sort_unit_defines.svh"

module mhs_datapath
  import mhs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] value_i,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] out_element_o,
  output logic               out_last_o,
  output logic [1:0]         out_status_o
);

  logic signed [31:0] mem [DEPTH];

  logic signed [31:0] rd_a_q, rd_b_q;
  logic signed [31:0] v_q, v_d;
  logic [CW-1:0]      p_q, p_d;
  logic [CW-1:0]      end_q, end_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      i_q, i_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_element_q;
  logic               out_last_q;
  logic [1:0]         out_status_q;

  logic               rd_a_en, rd_b_en;
  logic [AW-1:0]      ra, rb;
  logic               wr_en;
  logic [AW-1:0]      wa;
  logic signed [31:0] wd;

  logic [CW:0]        two_p;
  logic               has_right;
  logic               pick_right;
  logic signed [31:0] child_val;
  logic [CW-1:0]      child_pos;
  logic               emit_last;
  logic               out_free;
  logic               emit;
  logic signed [31:0] emit_element;
  logic [1:0]         emit_status;

  assign two_p      = {p_q, 1'b0};
  assign has_right  = (two_p + (CW+1)'(1)) <= {1'b0, end_q};
  assign pick_right = has_right && (rd_b_q > rd_a_q);
  assign child_val  = pick_right ? rd_b_q : rd_a_q;
  assign child_pos  = pick_right ? CW'(two_p + (CW+1)'(1)) : CW'(two_p);
  assign emit_last  = (CW'(i_q) + CW'(1)) == count_q;
  assign out_free   = !out_valid_q || out_ready_i;

  assign stat_o.full      = (count_q == CW'(DEPTH));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.at_root   = (p_q == CW'(1));
  assign stat_o.leaf      = two_p > {1'b0, end_q};
  assign stat_o.sort_done = (end_q <= CW'(1));
  assign stat_o.up_move   = v_q > rd_a_q;
  assign stat_o.dn_move   = child_val > v_q;
  assign stat_o.emit_last = emit_last;
  assign stat_o.out_free  = out_free;

  always_comb begin
    rd_a_en      = 1'b0;
    rd_b_en      = 1'b0;
    ra           = '0;
    rb           = '0;
    wr_en        = 1'b0;
    wa           = AW'(p_q - CW'(1));
    wd           = v_q;
    v_d          = v_q;
    p_d          = p_q;
    end_d        = end_q;
    count_d      = count_q;
    i_d          = i_q;
    emit         = 1'b0;
    emit_element = '0;
    emit_status  = ST_OK;
    case (cmd_i.op)
      OP_LOAD: begin
        v_d   = value_i;
        p_d   = count_q + CW'(1);
        end_d = count_q;
        i_d   = '0;
      end
      OP_INS_RD: begin
        rd_a_en = 1'b1;
        ra      = AW'((p_q >> 1) - CW'(1));
      end
      OP_INS_MOVE: begin
        wr_en = 1'b1;
        wd    = rd_a_q;
        p_d   = p_q >> 1;
      end
      OP_INS_PLACE: begin
        wr_en   = 1'b1;
        count_d = count_q + CW'(1);
      end
      OP_EMIT_INS: begin
        emit         = 1'b1;
        emit_element = v_q;
      end
      OP_EMIT_FULL: begin
        emit        = 1'b1;
        emit_status = ST_FULL;
      end
      OP_EMIT_EMPTY: begin
        emit        = 1'b1;
        emit_status = ST_EMPTY;
      end
      OP_SRT_RD: begin
        rd_a_en = 1'b1;
        rd_b_en = 1'b1;
        ra      = '0;
        rb      = AW'(end_q - CW'(1));
      end
      OP_SRT_SWAP: begin
        // old root goes to the tail, old tail sifts down from the root
        wr_en = 1'b1;
        wa    = AW'(end_q - CW'(1));
        wd    = rd_a_q;
        v_d   = rd_b_q;
        p_d   = CW'(1);
        end_d = end_q - CW'(1);
      end
      OP_SD_RD: begin
        rd_a_en = 1'b1;
        rd_b_en = 1'b1;
        ra      = AW'(two_p - (CW+1)'(1));
        rb      = AW'(two_p);
      end
      OP_SD_MOVE: begin
        wr_en = 1'b1;
        wd    = child_val;
        p_d   = child_pos;
      end
      OP_SD_PLACE: begin
        wr_en = 1'b1;
      end
      OP_RD_I: begin
        rd_a_en = 1'b1;
        ra      = i_q;
      end
      OP_EMIT: begin
        emit         = 1'b1;
        emit_element = rd_a_q;
        i_d          = i_q + AW'(1);
        if (cmd_i.clear_count && emit_last) begin
          count_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wa] <= wd;
    end
    if (rd_a_en) begin
      rd_a_q <= mem[ra];
    end
    if (rd_b_en) begin
      rd_b_q <= mem[rb];
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    p_q   <= p_d;
    end_q <= end_d;
    i_q   <= i_d;
    if (emit) begin
      out_element_q <= emit_element;
      out_last_q    <= (cmd_i.op == OP_EMIT) ? emit_last : 1'b1;
      out_status_q  <= emit_status;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_element_o = out_element_q;
  assign out_last_o    = out_last_q;
  assign out_status_o  = out_status_q;

  `MHS_ASSERT_NOW(a_emit_needs_room, emit, out_free, "item loaded while output stalled")
  `MHS_ASSERT_NEXT(a_place_counts, cmd_i.op == OP_INS_PLACE, count_q == $past(count_q) + CW'(1), "count not bumped on insert")
  `MHS_ASSERT_NOW(a_sift_in_bound, cmd_i.op == OP_SD_RD, two_p <= {1'b0, end_q}, "sift-down read past bound")
  `MHS_ASSERT_NOW(a_sift_up_not_root, cmd_i.op == OP_INS_RD, p_q > CW'(1), "sift-up read above root")

endmodule

@@ rtl/core/mhs_ctrl.sv @@
// Heap controller: sequences insert, display and heapsort over the datapath.
module mhs_ctrl
  import mhs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] action_i,
  output logic       in_ready_o,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INS_RD    = 4'd1;
  localparam logic [3:0] S_INS_CMP   = 4'd2;
  localparam logic [3:0] S_INS_EMIT  = 4'd3;
  localparam logic [3:0] S_FULL      = 4'd4;
  localparam logic [3:0] S_EMPTY     = 4'd5;
  localparam logic [3:0] S_SRT_RD    = 4'd6;
  localparam logic [3:0] S_SRT_SWAP  = 4'd7;
  localparam logic [3:0] S_SD_RD     = 4'd8;
  localparam logic [3:0] S_SD_CMP    = 4'd9;
  localparam logic [3:0] S_DISP_RD   = 4'd10;
  localparam logic [3:0] S_DISP_EMIT = 4'd11;

  logic [3:0] state_q, state_d;
  logic       sort_q, sort_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d           = state_q;
    sort_d            = sort_q;
    cmd_o.op          = OP_NONE;
    cmd_o.clear_count = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = OP_LOAD;
          sort_d   = (action_i == ACT_SORT);
          case (action_i)
            ACT_INSERT:  state_d = stat_i.full ? S_FULL : S_INS_RD;
            ACT_DISPLAY: state_d = stat_i.empty ? S_EMPTY : S_DISP_RD;
            ACT_SORT:    state_d = stat_i.empty ? S_EMPTY : S_SRT_RD;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_INS_RD: begin
        if (stat_i.at_root) begin
          cmd_o.op = OP_INS_PLACE;
          state_d  = S_INS_EMIT;
        end else begin
          cmd_o.op = OP_INS_RD;
          state_d  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat_i.up_move) begin
          cmd_o.op = OP_INS_MOVE;
          state_d  = S_INS_RD;
        end else begin
          cmd_o.op = OP_INS_PLACE;
          state_d  = S_INS_EMIT;
        end
      end
      S_INS_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT_INS;
          state_d  = S_IDLE;
        end
      end
      S_FULL: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT_FULL;
          state_d  = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT_EMPTY;
          state_d  = S_IDLE;
        end
      end
      S_SRT_RD: begin
        if (stat_i.sort_done) begin
          state_d = S_DISP_RD;
        end else begin
          cmd_o.op = OP_SRT_RD;
          state_d  = S_SRT_SWAP;
        end
      end
      S_SRT_SWAP: begin
        cmd_o.op = OP_SRT_SWAP;
        state_d  = S_SD_RD;
      end
      S_SD_RD: begin
        if (stat_i.leaf) begin
          cmd_o.op = OP_SD_PLACE;
          state_d  = S_SRT_RD;
        end else begin
          cmd_o.op = OP_SD_RD;
          state_d  = S_SD_CMP;
        end
      end
      S_SD_CMP: begin
        if (stat_i.dn_move) begin
          cmd_o.op = OP_SD_MOVE;
          state_d  = S_SD_RD;
        end else begin
          cmd_o.op = OP_SD_PLACE;
          state_d  = S_SRT_RD;
        end
      end
      S_DISP_RD: begin
        cmd_o.op = OP_RD_I;
        state_d  = S_DISP_EMIT;
      end
      S_DISP_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op          = OP_EMIT;
          cmd_o.clear_count = sort_q;
          state_d           = stat_i.emit_last ? S_IDLE : S_DISP_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sort_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sort_q  <= sort_d;
    end
  end

endmodule

@@ rtl/core/max_heap_insert_and_sort_unit.sv @@
// Binary max-heap with insert, display in array order and heapsort, top level.
//
// Input channel s_axis: tuser carries the action (insert, display, sort), tdata
// the signed value to insert. Output channel m_axis: tdata the element, tuser
// the status (ok, full, empty), tlast marks the final item of each run.
// An insert gives one item: the value, or status full with element zero.
// Display or sort on an empty heap gives one item with status empty.
// Display gives the stored elements in array order; sort gives them ascending
// and then leaves the heap empty. Action code three is taken and ignored.
// One item is worked on at a time; s_axis_tready is high only when idle.
// Each insert sift-up level reads the parent through the registered read port of
// the single-write element store, then compares and moves it down. Display reads
// and then emits each element. Sort does, per element but the last, a root swap
// (read root and tail, then swap), a read and compare per sift-down level and a
// place of the moved element, then a finish step. Results go through an output
// register, so a stall on m_axis holds the block in its emit step without loss.
// Reset empties the heap and clears the output valid; the store is not cleared.
module max_heap_insert_and_sort_unit
  import mhs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] value
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] element
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  cmd_t               cmd;
  stat_t              stat;
  logic signed [31:0] out_element;

  mhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .action_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mhs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (s_axis_tdata),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_element_o (out_element),
    .out_last_o    (m_axis_tlast),
    .out_status_o  (m_axis_tuser)
  );

  assign m_axis_tdata = out_element;

endmodule
